@@ rtl/bc_pkg.sv @@
// Package for the batch coalescer: widths, codes and controller/datapath interface types.
`default_nettype none
package bc_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int DATA_W = 32;
    localparam int BYTES_W = 40;
    localparam int COUNT_W = 6;
    localparam int CMP_W = COUNT_W + 1;
    localparam int MODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_CLOSE = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ELEM   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic prime;
        logic load_elem;
    } bc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic release_req;
        logic last_elem;
    } bc_stat_t;

endpackage
`default_nettype wire

@@ rtl/bc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/bc_ctrl.sv @@
// Controller state machine: transaction acceptance and batch drain sequencing.
`default_nettype none
module bc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bc_pkg::bc_stat_t stat,
    output bc_pkg::bc_cmd_t       cmd
);

    bc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            bc_pkg::ST_IDLE: begin
                s_ready    = stat.out_free;
                cmd.accept = s_valid && stat.out_free;
                if (cmd.accept && stat.release_req) begin
                    state_next = bc_pkg::ST_PRIME;
                end
            end
            bc_pkg::ST_PRIME: begin
                cmd.prime  = 1'b1;
                state_next = bc_pkg::ST_DRAIN;
            end
            bc_pkg::ST_DRAIN: begin
                if (stat.out_free) begin
                    cmd.load_elem = 1'b1;
                    if (stat.last_elem) begin
                        state_next = bc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = bc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/bc_dpath.sv @@
// Datapath: configuration, batch state, descriptor store and output register.
`default_nettype none
module bc_dpath #(
    parameter int STORE_DEPTH = bc_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [bc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bc_pkg::DATA_W-1:0]     cfg_wdata,
    input  wire logic [bc_pkg::MODE_W-1:0]     s_mode,
    input  wire logic [bc_pkg::DATA_W-1:0]     s_item_handle,
    input  wire logic [bc_pkg::DATA_W-1:0]     s_item_len,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic      [bc_pkg::STATUS_W-1:0]   m_status,
    output logic      [bc_pkg::DATA_W-1:0]     m_out_handle,
    output logic      [bc_pkg::DATA_W-1:0]     m_out_len,
    output logic      [bc_pkg::COUNT_W-1:0]    m_batch_size,
    output logic                               m_last,
    input  wire bc_pkg::bc_cmd_t               cmd,
    output bc_pkg::bc_stat_t                   stat
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int DW    = bc_pkg::DATA_W;
    localparam int BW    = bc_pkg::BYTES_W;
    localparam int CW    = bc_pkg::COUNT_W;
    localparam int XW    = bc_pkg::CMP_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_DEPTH);

    logic [CW-1:0]    count_limit_reg;
    logic [DW-1:0]    byte_limit_reg;
    logic [DW-1:0]    timeout_reg;
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [BW-1:0]    held_bytes_reg, held_bytes_next;
    logic [DW-1:0]    age_reg, age_next;
    logic             closed_reg, closed_next;
    logic [CNT_W-1:0] batch_reg;
    logic [IDX_W-1:0] elem_idx_reg;
    logic             m_valid_reg;

    bc_pkg::mode_t    mode;
    logic             len_zero;
    logic [CNT_W-1:0] count_inc;
    logic [BW-1:0]    bytes_sum;
    logic [DW-1:0]    age_inc;
    logic             push_ok;
    logic             push_trig;
    logic             release_now;
    logic             load_status;
    logic [bc_pkg::STATUS_W-1:0] push_status;

    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [2*DW-1:0]      ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_limit_reg <= '0;
            byte_limit_reg  <= '0;
            timeout_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bc_pkg::CFG_COUNT_LIMIT:   count_limit_reg <= cfg_wdata[CW-1:0];
                bc_pkg::CFG_BYTE_LIMIT:    byte_limit_reg  <= cfg_wdata;
                bc_pkg::CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        mode        = bc_pkg::mode_t'(s_mode);
        len_zero    = (s_item_len == '0);
        count_inc   = held_count_reg + CNT_W'(1);
        bytes_sum   = held_bytes_reg + BW'(s_item_len);
        age_inc     = (age_reg == '1) ? age_reg : age_reg + DW'(1);
        push_ok     = !len_zero && !closed_reg;
        push_trig   = ((count_limit_reg != '0) && (XW'(count_inc) >= XW'(count_limit_reg)))
                   || ((byte_limit_reg != '0) && (bytes_sum >= BW'(byte_limit_reg)))
                   || (count_inc == FULL_COUNT);

        if (len_zero) begin
            push_status = bc_pkg::ST_ZERO_LEN;
        end else if (closed_reg) begin
            push_status = bc_pkg::ST_SHUTDOWN;
        end else begin
            push_status = bc_pkg::ST_ACCEPTED;
        end

        unique case (mode)
            bc_pkg::MODE_PUSH:  release_now = push_ok && push_trig;
            bc_pkg::MODE_TICK:  release_now = (held_count_reg != '0) && (timeout_reg != '0)
                                           && (age_inc >= timeout_reg);
            bc_pkg::MODE_FLUSH: release_now = (held_count_reg != '0);
            bc_pkg::MODE_CLOSE: release_now = (held_count_reg != '0);
            default:            release_now = 1'b0;
        endcase

        held_count_next = held_count_reg;
        held_bytes_next = held_bytes_reg;
        age_next        = age_reg;
        closed_next     = closed_reg;
        if (cmd.accept) begin
            unique case (mode)
                bc_pkg::MODE_PUSH: begin
                    if (push_ok) begin
                        held_count_next = count_inc;
                        held_bytes_next = bytes_sum;
                        if (held_count_reg == '0) begin
                            age_next = '0;
                        end
                    end
                end
                bc_pkg::MODE_TICK: begin
                    if (held_count_reg != '0) begin
                        age_next = age_inc;
                    end
                end
                bc_pkg::MODE_FLUSH: ;
                bc_pkg::MODE_CLOSE: closed_next = 1'b1;
                default: ;
            endcase
            if (release_now) begin
                held_count_next = '0;
                held_bytes_next = '0;
                age_next        = '0;
            end
        end
    end

    assign load_status = cmd.accept && (mode == bc_pkg::MODE_PUSH);
    assign ram_we      = cmd.accept && (mode == bc_pkg::MODE_PUSH) && push_ok;
    assign ram_re      = cmd.prime || (cmd.load_elem && !stat.last_elem);
    assign ram_raddr   = cmd.prime ? '0 : elem_idx_reg + IDX_W'(1);

    bc_ram #(
        .WIDTH(2 * DW),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (held_count_reg[IDX_W-1:0]),
        .wdata ({s_item_handle, s_item_len}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            held_bytes_reg <= '0;
            age_reg        <= '0;
            closed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_count_reg <= held_count_next;
            held_bytes_reg <= held_bytes_next;
            age_reg        <= age_next;
            closed_reg     <= closed_next;
            if (load_status || cmd.load_elem) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && release_now) begin
            batch_reg <= (mode == bc_pkg::MODE_PUSH) ? count_inc : held_count_reg;
        end
        if (cmd.prime) begin
            elem_idx_reg <= '0;
        end else if (cmd.load_elem) begin
            elem_idx_reg <= elem_idx_reg + IDX_W'(1);
        end
        if (load_status) begin
            m_result_kind <= bc_pkg::KIND_STATUS;
            m_status      <= push_status;
            m_out_handle  <= '0;
            m_out_len     <= '0;
            m_batch_size  <= '0;
            m_last        <= 1'b0;
        end else if (cmd.load_elem) begin
            m_result_kind <= bc_pkg::KIND_ELEM;
            m_status      <= bc_pkg::ST_ACCEPTED;
            m_out_handle  <= ram_rdata[2*DW-1:DW];
            m_out_len     <= ram_rdata[DW-1:0];
            m_batch_size  <= CW'(batch_reg);
            m_last        <= stat.last_elem;
        end
    end

    assign m_valid          = m_valid_reg;
    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.release_req = release_now;
    assign stat.last_elem   = (CNT_W'(elem_idx_reg) == batch_reg - CNT_W'(1));

endmodule
`default_nettype wire

@@ rtl/batch_coalescer.sv @@
// Batch coalescer top level: count, byte and timeout triggered descriptor batching.
// A push status is loaded into the output register when its transaction is accepted.
// A released batch passes through PRIME, which reads the first entry from the descriptor
// store's registered read port; DRAIN sends one element per cycle while output is free.
// One transaction per cycle while output is free; a release holds input through the drain.
// Reset (aresetn, synchronous, active low) clears limits, counts, closed flag and output valid.
`default_nettype none
module batch_coalescer #(
    parameter int STORE_DEPTH = bc_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [bc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bc_pkg::DATA_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bc_pkg::MODE_W-1:0]     s_mode,
    input  wire logic [bc_pkg::DATA_W-1:0]     s_item_handle,
    input  wire logic [bc_pkg::DATA_W-1:0]     s_item_len,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic      [bc_pkg::STATUS_W-1:0]   m_status,
    output logic      [bc_pkg::DATA_W-1:0]     m_out_handle,
    output logic      [bc_pkg::DATA_W-1:0]     m_out_len,
    output logic      [bc_pkg::COUNT_W-1:0]    m_batch_size,
    output logic                               m_last
);

    bc_pkg::bc_cmd_t  cmd;
    bc_pkg::bc_stat_t stat;

    bc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bc_dpath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_mode        (s_mode),
        .s_item_handle (s_item_handle),
        .s_item_len    (s_item_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_status      (m_status),
        .m_out_handle  (m_out_handle),
        .m_out_len     (m_out_len),
        .m_batch_size  (m_batch_size),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire

@@ tb/batch_coalescer_tb.sv @@
// Testbench for batch_coalescer: directed and random transactions checked against a predictor.
`timescale 1ns / 1ps
module batch_coalescer_tb;

    localparam int DEPTH = bc_pkg::STORE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE = 8;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic                        kind;
        logic [bc_pkg::STATUS_W-1:0] status;
        logic [bc_pkg::DATA_W-1:0]   handle;
        logic [bc_pkg::DATA_W-1:0]   len;
        logic [bc_pkg::COUNT_W-1:0]  size;
        logic                        last;
    } batch_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_we;
    logic [bc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bc_pkg::DATA_W-1:0]    cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic [bc_pkg::MODE_W-1:0]    s_mode;
    logic [bc_pkg::DATA_W-1:0]    s_item_handle;
    logic [bc_pkg::DATA_W-1:0]    s_item_len;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_result_kind;
    logic [bc_pkg::STATUS_W-1:0]  m_status;
    logic [bc_pkg::DATA_W-1:0]    m_out_handle;
    logic [bc_pkg::DATA_W-1:0]    m_out_len;
    logic [bc_pkg::COUNT_W-1:0]   m_batch_size;
    logic                         m_last;

    // predicted block state
    logic [bc_pkg::COUNT_W-1:0] lim_count;
    logic [bc_pkg::DATA_W-1:0]  lim_bytes;
    logic [bc_pkg::DATA_W-1:0]  lim_ticks;
    logic [bc_pkg::DATA_W-1:0]  held_handle [DEPTH];
    logic [bc_pkg::DATA_W-1:0]  held_len [DEPTH];
    int                         held_n;
    logic [bc_pkg::BYTES_W-1:0] held_sum;
    logic [bc_pkg::DATA_W-1:0]  held_age;
    bit                         shut;

    batch_result_t expected_results[$];
    batch_result_t want;
    int            errors = 0;
    int            cycles = 0;
    bit            calm;
    int            stall_requests = 0;
    int            stall_served = 0;
    int            stall_left = 0;

    batch_coalescer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_item_handle (s_item_handle),
        .s_item_len    (s_item_len),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_status      (m_status),
        .m_out_handle  (m_out_handle),
        .m_out_len     (m_out_len),
        .m_batch_size  (m_batch_size),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("batch_coalescer regression: fail");
            $finish;
        end
    end

    function automatic void expect_status(logic [bc_pkg::STATUS_W-1:0] st);
        batch_result_t r;
        r = '0;
        r.kind = bc_pkg::KIND_STATUS;
        r.status = st;
        expected_results.push_back(r);
    endfunction

    function automatic void release_held();
        batch_result_t r;
        for (int i = 0; i < held_n; i++) begin
            r = '0;
            r.kind = bc_pkg::KIND_ELEM;
            r.handle = held_handle[i];
            r.len = held_len[i];
            r.size = bc_pkg::COUNT_W'(held_n);
            r.last = (i == held_n - 1);
            expected_results.push_back(r);
        end
        held_n = 0;
        held_sum = '0;
        held_age = '0;
    endfunction

    function automatic void predict_batch(bc_pkg::mode_t md, logic [bc_pkg::DATA_W-1:0] h,
                                          logic [bc_pkg::DATA_W-1:0] l);
        unique case (md)
            bc_pkg::MODE_PUSH: begin
                if (l == '0) begin
                    expect_status(bc_pkg::ST_ZERO_LEN);
                end else if (shut) begin
                    expect_status(bc_pkg::ST_SHUTDOWN);
                end else begin
                    held_handle[held_n] = h;
                    held_len[held_n] = l;
                    held_n++;
                    held_sum = held_sum + bc_pkg::BYTES_W'(l);
                    if (held_n == 1) held_age = '0;
                    expect_status(bc_pkg::ST_ACCEPTED);
                    if ((lim_count != '0 && held_n >= lim_count) ||
                        (lim_bytes != '0 && held_sum >= bc_pkg::BYTES_W'(lim_bytes)) ||
                        held_n >= DEPTH)
                        release_held();
                end
            end
            bc_pkg::MODE_TICK: begin
                if (held_n != 0) begin
                    if (held_age != '1) held_age++;
                    if (lim_ticks != '0 && held_age >= lim_ticks) release_held();
                end
            end
            bc_pkg::MODE_FLUSH: begin
                if (held_n != 0) release_held();
            end
            bc_pkg::MODE_CLOSE: begin
                if (held_n != 0) release_held();
                shut = 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [bc_pkg::DATA_W-1:0] want_v,
                                        logic [bc_pkg::DATA_W-1:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction: expected none, actual kind %0h status %0h",
                         $time, m_result_kind, m_status);
                $display("    handle %0h len %0h size %0d last %0b",
                         m_out_handle, m_out_len, m_batch_size, m_last);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, m_result_kind);
                check_field("status", want.status, m_status);
                check_field("out_handle", want.handle, m_out_handle);
                check_field("out_len", want.len, m_out_len);
                check_field("batch_size", want.size, m_batch_size);
                check_field("last", want.last, m_last);
            end
        end
    end

    // receiver: random idling, plus a long hold-off on request
    always @(negedge aclk) begin
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    // called and returns at a falling edge
    task automatic send_item(bc_pkg::mode_t md, logic [bc_pkg::DATA_W-1:0] h,
                             logic [bc_pkg::DATA_W-1:0] l);
        int gap;
        gap = (!calm && $urandom_range(99) < 35) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_item_handle <= h;
        s_item_len <= l;
        do @(posedge aclk); while (!s_ready);
        predict_batch(md, h, l);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [bc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bc_pkg::DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            bc_pkg::CFG_COUNT_LIMIT: lim_count = val[bc_pkg::COUNT_W-1:0];
            bc_pkg::CFG_BYTE_LIMIT:  lim_bytes = val;
            default:                 lim_ticks = val;
        endcase
    endtask

    task automatic set_limits(logic [bc_pkg::DATA_W-1:0] c, logic [bc_pkg::DATA_W-1:0] b,
                              logic [bc_pkg::DATA_W-1:0] t);
        wait_drained();
        cfg_write(bc_pkg::CFG_COUNT_LIMIT, c);
        cfg_write(bc_pkg::CFG_BYTE_LIMIT, b);
        cfg_write(bc_pkg::CFG_TIMEOUT_TICKS, t);
    endtask

    // all limits zero after reset: only flush releases here
    task automatic test_push_status();
        send_item(bc_pkg::MODE_PUSH, 32'h0000_0000, 32'h0000_0001);
        send_item(bc_pkg::MODE_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(bc_pkg::MODE_PUSH, 32'h1234_5678, 32'h0000_0000);
        send_item(bc_pkg::MODE_TICK, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_FLUSH, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_FLUSH, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_TICK, 32'h0, 32'h0);
    endtask

    task automatic test_count_limit();
        set_limits(32'd1, 32'd0, 32'd0);
        send_item(bc_pkg::MODE_PUSH, 32'hA5A5_A5A5, 32'd7);
        send_item(bc_pkg::MODE_PUSH, 32'h5A5A_5A5A, 32'd9);
        set_limits(32'd3, 32'd0, 32'd0);
        repeat (3) send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 50));
    endtask

    task automatic test_byte_limit();
        set_limits(32'd0, 32'd100, 32'd0);
        send_item(bc_pkg::MODE_PUSH, 32'h0000_0011, 32'd60);
        send_item(bc_pkg::MODE_PUSH, 32'h0000_0022, 32'd40);
        set_limits(32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(bc_pkg::MODE_PUSH, 32'h0000_0033, 32'hFFFF_FFFF);
    endtask

    task automatic test_timeout();
        set_limits(32'd0, 32'd0, 32'd3);
        send_item(bc_pkg::MODE_PUSH, 32'hCAFE_0001, 32'd5);
        repeat (3) send_item(bc_pkg::MODE_TICK, 32'h0, 32'h0);
        set_limits(32'd0, 32'd0, 32'd1);
        send_item(bc_pkg::MODE_PUSH, 32'hCAFE_0002, 32'd6);
        send_item(bc_pkg::MODE_TICK, 32'h0, 32'h0);
    endtask

    // count limit above the store depth: the full store releases first
    task automatic test_store_full();
        set_limits(32'd63, 32'd0, 32'd0);
        for (int i = 0; i < DEPTH; i++)
            send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 1000));
    endtask

    // lowering a limit releases nothing until the next push
    task automatic test_limit_lowered();
        set_limits(32'd0, 32'd0, 32'd0);
        repeat (5) send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 100));
        set_limits(32'd2, 32'd0, 32'd0);
        send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 100));
    endtask

    task automatic random_items(int n);
        bc_pkg::mode_t             md;
        int                        pick;
        logic [bc_pkg::DATA_W-1:0] len;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 72) md = bc_pkg::MODE_PUSH;
            else if (pick < 93) md = bc_pkg::MODE_TICK;
            else md = bc_pkg::MODE_FLUSH;
            pick = $urandom_range(99);
            if (pick < 5) len = '0;
            else if (pick < 55) len = $urandom_range(1, 64);
            else if (pick < 62) len = '1;
            else len = $urandom;
            if ($urandom_range(99) < 3) wait_drained();
            send_item(md, $urandom, len);
        end
    endtask

    task automatic test_random_mix();
        logic [bc_pkg::DATA_W-1:0] cnt;
        logic [bc_pkg::DATA_W-1:0] bytes_lim;
        logic [bc_pkg::DATA_W-1:0] ticks;
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(3))
                0:       cnt = 0;
                1:       cnt = $urandom_range(1, 8);
                2:       cnt = $urandom_range(9, 32);
                default: cnt = $urandom_range(33, 63);
            endcase
            case ($urandom_range(3))
                0:       bytes_lim = 0;
                1:       bytes_lim = $urandom_range(1, 400);
                2:       bytes_lim = $urandom;
                default: bytes_lim = '1;
            endcase
            case ($urandom_range(2))
                0:       ticks = 0;
                1:       ticks = $urandom_range(1, 6);
                default: ticks = '1;
            endcase
            calm = (ph == 4);
            set_limits(cnt, bytes_lim, ticks);
            random_items(28);
        end
        calm = 1'b0;
    endtask

    // long receiver hold-off while pushes keep coming
    task automatic test_output_backpressure();
        set_limits(32'd4, 32'd0, 32'd0);
        stall_requests++;
        repeat (60) send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 1000));
        wait_drained();
    endtask

    task automatic test_close();
        set_limits(32'd0, 32'd0, 32'd0);
        repeat (3) send_item(bc_pkg::MODE_PUSH, $urandom, $urandom_range(1, 100));
        send_item(bc_pkg::MODE_CLOSE, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_PUSH, 32'hDEAD_BEEF, 32'd8);
        send_item(bc_pkg::MODE_PUSH, 32'hDEAD_BEEF, 32'd0);
        send_item(bc_pkg::MODE_TICK, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_FLUSH, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_CLOSE, 32'h0, 32'h0);
        send_item(bc_pkg::MODE_PUSH, $urandom, 32'hFFFF_FFFF);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bc_pkg::CFG_COUNT_LIMIT;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = bc_pkg::MODE_PUSH;
        s_item_handle = '0;
        s_item_len = '0;
        calm = 1'b0;
        lim_count = '0;
        lim_bytes = '0;
        lim_ticks = '0;
        held_n = 0;
        held_sum = '0;
        held_age = '0;
        shut = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_push_status();
        test_count_limit();
        test_byte_limit();
        test_timeout();
        test_store_full();
        test_limit_lowered();
        test_random_mix();
        test_output_backpressure();
        test_close();
        wait_drained();

        if (errors == 0) begin
            $display("batch_coalescer regression: pass");
        end else begin
            $display("batch_coalescer regression: fail");
        end
        $finish;
    end

endmodule
